### rtl/wstd_pkg.sv
// ----------------------------------------------------------------------------
// Work-stealing task deques: shared types and constants
// Request and result payloads, status and operation codes, back-end states.
// ----------------------------------------------------------------------------
package wstd_pkg;

  localparam int CFG_BITS    = 4;
  localparam int OP_BITS     = 1;
  localparam int ID_BITS     = 3;
  localparam int HANDLE_BITS = 16;
  localparam int STATUS_BITS = 3;

  localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 4'd8;

  localparam logic [OP_BITS-1:0] OP_RELEASE = 1'b0;
  localparam logic [OP_BITS-1:0] OP_FETCH   = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_PUSHED = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_LOCAL  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_STOLE  = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_FULL   = 3'd4;

  typedef struct packed {
    logic [OP_BITS-1:0]     op;
    logic [ID_BITS-1:0]     worker_id;
    logic [HANDLE_BITS-1:0] task_handle;
  } request_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [HANDLE_BITS-1:0] task_out;
    logic [ID_BITS-1:0]     victim_id;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ACCESS,
    BK_REPLY
  } back_state_t;

endpackage

### rtl/wstd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wstd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/wstd_fifo.sv
// ----------------------------------------------------------------------------
// Small register FIFO
// Holds a few packed entries; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module wstd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_BITS = $clog2(DEPTH),
  localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  output logic                full,
  input  logic                pop,
  output logic [WIDTH-1:0]    rdata,
  output logic                empty,
  output logic [CNT_BITS-1:0] count
);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/wstd_front.sv
// ----------------------------------------------------------------------------
// Work-stealing deques: front end
// Holds the active worker count, accepts requests, resolves the physical
// queue and the first steal candidate, and queues commands for the back end.
// ----------------------------------------------------------------------------
module wstd_front #(
  parameter int MAX_WORKERS = 8,
  parameter int TASK_BITS   = 16,
  localparam int WB    = $clog2(MAX_WORKERS),
  localparam int AW    = $clog2(MAX_WORKERS + 1),
  localparam int CMD_W = 1 + WB + WB + AW + TASK_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wstd_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          push,
  output logic                          full,
  input  wstd_pkg::request_t            request,
  input  logic                          cmd_pop,
  output logic                          cmd_empty,
  output logic [CMD_W-1:0]              cmd
);

  localparam int NUM_IDS = 2 ** wstd_pkg::ID_BITS;

  typedef struct packed {
    logic                 op;
    logic [WB-1:0]        wid;
    logic [WB-1:0]        start;
    logic [AW-1:0]        active;
    logic [TASK_BITS-1:0] handle;
  } cmd_t;

  logic [wstd_pkg::CFG_BITS-1:0] active_workers;
  logic [WB-1:0]                 wid_tbl [NUM_IDS];
  logic [AW-1:0]                 eff_active;
  logic [WB-1:0]                 start;
  cmd_t                          cmd_in;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= wstd_pkg::ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_workers <= cfg_data;
    end
  end

  // Worker ids wrap at the number of physical queues.
  for (genvar i = 0; i < NUM_IDS; i++) begin : g_wid
    localparam int WrappedId = i % MAX_WORKERS;
    assign wid_tbl[i] = WB'(WrappedId);
  end

  always_comb begin
    if (active_workers == '0) begin
      eff_active = AW'(1);
    end else if (32'(active_workers) > MAX_WORKERS) begin
      eff_active = AW'(MAX_WORKERS);
    end else begin
      eff_active = AW'(active_workers);
    end
  end

  // The steal search starts at (worker + 1) mod active count. The worker id
  // is at most seven, so a few conditional subtractions reduce it.
  always_comb begin
    logic [AW-1:0] rem;
    rem = AW'(wid_tbl[request.worker_id]) + AW'(1);
    for (int i = 0; i < NUM_IDS; i++) begin
      if (rem >= eff_active) begin
        rem = rem - eff_active;
      end
    end
    start = WB'(rem);
  end

  always_comb begin
    cmd_in.op     = (request.op == wstd_pkg::OP_FETCH);
    cmd_in.wid    = wid_tbl[request.worker_id];
    cmd_in.start  = start;
    cmd_in.active = eff_active;
    cmd_in.handle = TASK_BITS'(request.task_handle);
  end

  wstd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty),
    .count ()
  );

endmodule

### rtl/wstd_back.sv
// ----------------------------------------------------------------------------
// Work-stealing deques: back end
// Picks the target queue, updates its entry count and (push, local pop) front
// index, and performs the single task store write or read for each command.
// ----------------------------------------------------------------------------
module wstd_back #(
  parameter int MAX_WORKERS = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int TASK_BITS   = 16,
  parameter int RES_DEPTH   = 2,
  localparam int WB    = $clog2(MAX_WORKERS),
  localparam int AW    = $clog2(MAX_WORKERS + 1),
  localparam int CMD_W = 1 + WB + WB + AW + TASK_BITS,
  localparam int RCB   = $clog2(RES_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_empty,
  input  logic [CMD_W-1:0]   cmd,
  output logic               cmd_pop,
  input  logic [RCB-1:0]     res_count,
  output logic               res_push,
  output wstd_pkg::result_t  res
);

  localparam int QB = $clog2(QUEUE_DEPTH);
  localparam int CB = $clog2(QUEUE_DEPTH + 1);
  localparam int DA = $clog2(MAX_WORKERS * QUEUE_DEPTH);

  typedef struct packed {
    logic                 op;
    logic [WB-1:0]        wid;
    logic [WB-1:0]        start;
    logic [AW-1:0]        active;
    logic [TASK_BITS-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [QB-1:0] front;
    logic [CB-1:0] count;
  } meta_t;

  wstd_pkg::back_state_t state;
  wstd_pkg::back_state_t state_next;

  cmd_t                          head;
  logic                          start_item;
  logic                          room;
  logic [wstd_pkg::STATUS_BITS-1:0] pick_status;
  logic [WB-1:0]                 pick_q;

  logic [wstd_pkg::STATUS_BITS-1:0] cur_status;
  logic [WB-1:0]                 cur_q;
  logic [TASK_BITS-1:0]          cur_handle;

  logic [MAX_WORKERS-1:0]        nonempty;
  logic [MAX_WORKERS-1:0]        full_q;
  logic [MAX_WORKERS-1:0]        meta_valid;

  meta_t                         meta_rdata;
  meta_t                         meta_cur;
  meta_t                         meta_wdata;
  logic                          meta_we;
  logic [QB-1:0]                 slot;
  logic [DA-1:0]                 deq_addr;
  logic                          deq_we;
  logic [TASK_BITS-1:0]          deq_rdata;
  logic                          got_task;

  assign head = cmd_t'(cmd);

  // A started command pushes its result in the reply state, so reserve a slot.
  assign room = (32'(res_count) + ((state == wstd_pkg::BK_REPLY) ? 1 : 0)) < RES_DEPTH;
  assign start_item = (state != wstd_pkg::BK_ACCESS) && !cmd_empty && room;

  // Queue selection. A fetch from an empty own queue scans the active queues
  // from the start index upward, then wraps to the lowest ones.
  always_comb begin
    logic          hi_found;
    logic          lo_found;
    logic [WB-1:0] hi_idx;
    logic [WB-1:0] lo_idx;
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_idx   = '0;
    lo_idx   = '0;
    for (int i = 0; i < MAX_WORKERS; i++) begin
      if (nonempty[i] && (AW'(i) < head.active)) begin
        if (!hi_found && (WB'(i) >= head.start)) begin
          hi_found = 1'b1;
          hi_idx   = WB'(i);
        end
        if (!lo_found) begin
          lo_found = 1'b1;
          lo_idx   = WB'(i);
        end
      end
    end
    pick_q      = head.wid;
    pick_status = wstd_pkg::ST_EMPTY;
    if (!head.op) begin
      pick_status = full_q[head.wid] ? wstd_pkg::ST_FULL : wstd_pkg::ST_PUSHED;
    end else if (nonempty[head.wid]) begin
      pick_status = wstd_pkg::ST_LOCAL;
    end else if (hi_found) begin
      pick_status = wstd_pkg::ST_STOLE;
      pick_q      = hi_idx;
    end else if (lo_found) begin
      pick_status = wstd_pkg::ST_STOLE;
      pick_q      = lo_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wstd_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    unique case (state)
      wstd_pkg::BK_IDLE:   state_next = start_item ? wstd_pkg::BK_ACCESS : wstd_pkg::BK_IDLE;
      wstd_pkg::BK_ACCESS: state_next = wstd_pkg::BK_REPLY;
      wstd_pkg::BK_REPLY:  state_next = start_item ? wstd_pkg::BK_ACCESS : wstd_pkg::BK_IDLE;
      default:             state_next = wstd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = start_item;
    res_push = (state == wstd_pkg::BK_REPLY);
  end

  always_ff @(posedge clk) begin
    if (start_item) begin
      cur_status <= pick_status;
      cur_q      <= pick_q;
      cur_handle <= head.handle;
    end
  end

  // Queue bookkeeping, valid during the access cycle. A queue never written
  // reads as front zero and no entries.
  always_comb begin
    logic [CB:0] back_pos;
    meta_cur = meta_valid[cur_q] ? meta_rdata : '0;
    back_pos = (CB+1)'(meta_cur.front) + (CB+1)'(meta_cur.count) - (CB+1)'(1);
    if (back_pos >= (CB+1)'(QUEUE_DEPTH)) begin
      back_pos = back_pos - (CB+1)'(QUEUE_DEPTH);
    end
    meta_wdata = meta_cur;
    slot       = meta_cur.front;
    unique case (cur_status)
      wstd_pkg::ST_PUSHED: begin
        slot = (meta_cur.front == '0) ? QB'(QUEUE_DEPTH - 1) : meta_cur.front - QB'(1);
        meta_wdata.front = slot;
        meta_wdata.count = meta_cur.count + CB'(1);
      end
      wstd_pkg::ST_LOCAL: begin
        meta_wdata.front = (meta_cur.front == QB'(QUEUE_DEPTH - 1)) ? '0
                         : meta_cur.front + QB'(1);
        meta_wdata.count = meta_cur.count - CB'(1);
      end
      wstd_pkg::ST_STOLE: begin
        slot = QB'(back_pos);
        meta_wdata.count = meta_cur.count - CB'(1);
      end
      default: begin
      end
    endcase
    meta_we = (state == wstd_pkg::BK_ACCESS) &&
              ((cur_status == wstd_pkg::ST_PUSHED) || (cur_status == wstd_pkg::ST_LOCAL) ||
               (cur_status == wstd_pkg::ST_STOLE));
    deq_we   = (state == wstd_pkg::BK_ACCESS) && (cur_status == wstd_pkg::ST_PUSHED);
    deq_addr = DA'(32'(cur_q) * QUEUE_DEPTH + 32'(slot));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty   <= '0;
      full_q     <= '0;
      meta_valid <= '0;
    end else if (meta_we) begin
      meta_valid[cur_q] <= 1'b1;
      nonempty[cur_q]   <= (meta_wdata.count != '0);
      full_q[cur_q]     <= (meta_wdata.count == CB'(QUEUE_DEPTH));
    end
  end

  wstd_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (MAX_WORKERS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (cur_q),
    .wdata (meta_wdata),
    .raddr (pick_q),
    .rdata (meta_rdata)
  );

  wstd_ram #(
    .WIDTH (TASK_BITS),
    .DEPTH (MAX_WORKERS * QUEUE_DEPTH)
  ) u_task_ram (
    .clk   (clk),
    .we    (deq_we),
    .waddr (deq_addr),
    .wdata (cur_handle),
    .raddr (deq_addr),
    .rdata (deq_rdata)
  );

  assign got_task = (cur_status == wstd_pkg::ST_LOCAL) || (cur_status == wstd_pkg::ST_STOLE);

  always_comb begin
    res.status    = cur_status;
    res.task_out  = got_task ? wstd_pkg::HANDLE_BITS'(deq_rdata) : '0;
    res.victim_id = got_task ? wstd_pkg::ID_BITS'(cur_q) : '0;
  end

endmodule

### rtl/work_stealing_task_deques.sv
// Path: a request's result reaches the result ports after it passes through the command FIFO,
// the back end's access and reply states and the result FIFO.
// Overlap: the back end starts a new request only once the previous one has left its access
// state, since the queue bookkeeping RAM read is followed by the single task store access.
// Reset: all queues empty, front indexes zero, active worker count eight. The task store
// contents stay undefined after reset; only slots holding live entries are ever returned.
// ----------------------------------------------------------------------------
// Work-stealing task deques
// Per-worker double-ended task queues with local pop and round-robin stealing.
// ----------------------------------------------------------------------------
module work_stealing_task_deques #(
  parameter int MAX_WORKERS = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int TASK_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wstd_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          push,
  output logic                          full,
  input  wstd_pkg::request_t            request,
  output logic                          empty,
  input  logic                          pop,
  output wstd_pkg::result_t             result
);

  localparam int WB        = $clog2(MAX_WORKERS);
  localparam int AW        = $clog2(MAX_WORKERS + 1);
  localparam int CMD_W     = 1 + WB + WB + AW + TASK_BITS;
  localparam int RES_DEPTH = 2;
  localparam int RCB       = $clog2(RES_DEPTH + 1);
  localparam int RES_W     = $bits(wstd_pkg::result_t);

  logic                cmd_pop;
  logic                cmd_empty;
  logic [CMD_W-1:0]    cmd;
  logic [RCB-1:0]      res_count;
  logic                res_push;
  wstd_pkg::result_t   res;
  logic [RES_W-1:0]    res_rdata;

  wstd_front #(
    .MAX_WORKERS (MAX_WORKERS),
    .TASK_BITS   (TASK_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  wstd_back #(
    .MAX_WORKERS (MAX_WORKERS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_BITS   (TASK_BITS),
    .RES_DEPTH   (RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res       (res)
  );

  // The back end only starts a command when a result slot is reserved.
  wstd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty),
    .count (res_count)
  );

  assign result = wstd_pkg::result_t'(res_rdata);

endmodule
